### rtl/core/kwm_pkg.sv
// Shared types and codes for the k-way sorted merge block.
// No dependencies; compile first.
package kwm_pkg;

  // Input beat: command, target list and value to append
  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         list_id;
    logic signed [31:0] value;
  } in_item_t;

  // Result beat: popped value, its list and a status code
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         source_list;
    logic [2:0]         status;
  } out_item_t;

  // Command codes (the high bit alone selects clear)
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Status codes
  localparam logic [2:0] STAT_LOADED  = 3'd0;
  localparam logic [2:0] STAT_POPPED  = 3'd1;
  localparam logic [2:0] STAT_EMPTY   = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

endpackage

### rtl/core/kwm_in_if.sv
// Input channel of the k-way sorted merge: valid/ready with a command beat.
// Depends on kwm_pkg.
interface kwm_in_if;
  import kwm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/kwm_out_if.sv
// Result channel of the k-way sorted merge: valid/ready with a result beat.
// Depends on kwm_pkg.
interface kwm_out_if;
  import kwm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/k_way_sorted_merge.sv
// K-way sorted merge: values are appended to up to NUM_LISTS lists held in one
// element RAM (NUM_LISTS*LIST_DEPTH words, registered read); each pop returns the
// smallest current head (ties to the lowest list) and advances that list. Per-list
// fill and read counts sit in a small RAM with a valid bit per list, so a clear
// takes effect at once and no clearing pass is needed after reset. One item is
// worked at a time: a load passes through the load state, a clear goes straight
// to the done state, and a pop runs a scan that reads one list head per cycle
// through the counter RAM and then the element RAM. A result waits in an output
// register; the next input beat is taken once that register can accept it.
// Depends on kwm_pkg, kwm_in_if and kwm_out_if.
module k_way_sorted_merge #(
  parameter int NUM_LISTS  = 16,
  parameter int LIST_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  kwm_in_if.sink    in_ch,
  kwm_out_if.source out_ch
);
  import kwm_pkg::*;

  localparam int LW = $clog2(NUM_LISTS);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(NUM_LISTS * LIST_DEPTH);
  localparam logic [LW:0]   NUM_C   = (LW + 1)'(NUM_LISTS);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(LIST_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  typedef struct packed {
    logic [CW-1:0] fill;
    logic [CW-1:0] rptr;
  } cnt_t;

  logic [1:0]  state;
  logic [LW:0] scan_idx;

  // Scan pipeline
  logic          s1_vld;
  logic [LW-1:0] s1_list;
  logic          s2_vld;
  logic [LW-1:0] s2_list;
  cnt_t          s2_cnt;

  // Running minimum
  logic               found;
  logic [LW-1:0]      best_list;
  cnt_t               best_cnt;
  logic signed [31:0] best_val;

  // Pending load and pending result
  logic [LW-1:0] ld_list;
  logic [31:0]   ld_value;
  out_item_t     res;

  // Counter RAM with per-list valid bits
  cnt_t           cnt_mem [NUM_LISTS];
  cnt_t           cnt_q;
  logic           cnt_q_vld;
  cnt_t           cnt_cur;
  logic [NUM_LISTS-1:0] cnt_vld;
  logic [LW-1:0]  cnt_raddr;
  logic           cnt_we;
  logic [LW-1:0]  cnt_waddr;
  cnt_t           cnt_wdata;

  // Element RAM
  logic [31:0]   elem_mem [NUM_LISTS * LIST_DEPTH];
  logic [31:0]   elem_q;
  logic [AW-1:0] elem_raddr;
  logic [AW-1:0] elem_waddr;
  logic          elem_we;

  logic in_acc;
  logic out_free;
  logic issuing;
  logic live;
  logic load_ok;
  logic scan_end;
  logic head_wins;

  // Handshake and decode
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  // Counter read: target list while idle, scan index during a pop
  assign cnt_raddr = (state == S_IDLE) ? LW'(in_ch.data.list_id) : scan_idx[LW-1:0];
  assign cnt_cur   = cnt_q_vld ? cnt_q : '0;

  assign issuing   = (state == S_SCAN) && (scan_idx < NUM_C);
  assign live      = s1_vld && (cnt_cur.rptr < cnt_cur.fill);
  assign scan_end  = (state == S_SCAN) && !issuing && !s1_vld && !s2_vld;
  assign head_wins = s2_vld && (!found || ($signed(elem_q) < best_val));
  assign load_ok   = (state == S_LOAD) && (cnt_cur.fill < DEPTH_C);

  // Element RAM addressing
  assign elem_raddr = AW'(s1_list) * DEPTH_A + AW'(cnt_cur.rptr);
  assign elem_waddr = AW'(ld_list) * DEPTH_A + AW'(cnt_cur.fill);
  assign elem_we    = load_ok;

  // Counter write-back: bump fill on load, bump read pointer of the winner
  always_comb begin
    if (state == S_LOAD) begin
      cnt_waddr      = ld_list;
      cnt_wdata.fill = CW'(cnt_cur.fill + 1'b1);
      cnt_wdata.rptr = cnt_cur.rptr;
    end else begin
      cnt_waddr      = best_list;
      cnt_wdata.fill = best_cnt.fill;
      cnt_wdata.rptr = CW'(best_cnt.rptr + 1'b1);
    end
  end
  assign cnt_we = load_ok || (scan_end && found);

  // Counter RAM
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q     <= cnt_mem[cnt_raddr];
    cnt_q_vld <= cnt_vld[cnt_raddr];
  end

  // Element RAM
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= ld_value;
    end
    elem_q <= elem_mem[elem_raddr];
  end

  // Per-list valid bits: drop all on clear, set on write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (in_acc && in_ch.data.mode[1]) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[cnt_waddr] <= 1'b1;
    end
  end

  // Control: sequencer, scan counter and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      found    <= 1'b0;
    end else begin
      s1_vld <= issuing;
      s2_vld <= live;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority if (in_ch.data.mode[1]) begin
              state <= S_DONE;
            end else if (in_ch.data.mode == MODE_LOAD) begin
              state <= (32'(in_ch.data.list_id) >= NUM_LISTS) ? S_DONE : S_LOAD;
            end else begin
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_LOAD: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (issuing) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (head_wins) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: pipeline data, running minimum and pending result
  always_ff @(posedge clk) begin
    s1_list <= scan_idx[LW-1:0];
    s2_list <= s1_list;
    s2_cnt  <= cnt_cur;
    if (head_wins) begin
      best_list <= s2_list;
      best_cnt  <= s2_cnt;
      best_val  <= $signed(elem_q);
    end
    if (in_acc) begin
      ld_list  <= LW'(in_ch.data.list_id);
      ld_value <= in_ch.data.value;
      res      <= '{out_value: 32'sd0, source_list: 4'd0,
                    status: in_ch.data.mode[1] ? STAT_CLEARED : STAT_FULL};
    end else if (state == S_LOAD) begin
      res.status <= load_ok ? STAT_LOADED : STAT_FULL;
    end else if (scan_end) begin
      if (found) begin
        res.out_value   <= best_val;
        res.source_list <= 4'(best_list);
        res.status      <= STAT_POPPED;
      end else begin
        res.out_value   <= '0;
        res.source_list <= '0;
        res.status      <= STAT_EMPTY;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_ch.data <= res;
    end
  end

  // A clear beat empties every list by the next cycle
  a_clear_drops_lists: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.data.mode[1] |=> cnt_vld == '0)
    else $error("lists not emptied after clear");

  // The scan pipeline is drained whenever a new beat can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !s1_vld && !s2_vld)
    else $error("scan pipeline busy while idle");

  // Only a successful pop carries a value and a list number
  a_zero_unless_pop: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.data.status != STAT_POPPED)
      |-> (out_ch.data.out_value == '0) && (out_ch.data.source_list == '0))
    else $error("non-pop result carries data");

  // A counter write-back only happens at the end of a load or a pop scan
  a_write_back_timing: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (state == S_LOAD) || scan_end)
    else $error("counter write outside load or scan end");

endmodule

### bench/kwm_merge_checker.sv
// Checker for the k-way sorted merge: predicts each result beat from the command beats
// and compares it field by field with what the block returns.
// Depends on kwm_pkg, kwm_in_if and kwm_out_if.
module kwm_merge_checker #(
  parameter int NUM_LISTS  = 16,
  parameter int LIST_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  kwm_in_if    cmd_ch,
  kwm_out_if   res_ch,
  output int   fail_count,
  output int   results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  // Shadow copy of the lists: stored values, values appended, values popped
  logic signed [31:0] list_mem [NUM_LISTS][LIST_DEPTH];
  int unsigned        list_fill [NUM_LISTS];
  int unsigned        list_head [NUM_LISTS];

  out_item_t results_due[$];
  int        errors = 0;

  // Apply one command to the shadow lists and return the result it should give
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t res;
    bit        found;
    int        pick;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    if (cmd.mode[1]) begin
      // high bit alone selects clear, so the spare code clears as well
      foreach (list_fill[i]) begin
        list_fill[i] = 0;
        list_head[i] = 0;
      end
      res.status = STAT_CLEARED;
    end else if (cmd.mode == MODE_LOAD) begin
      // pops never free space: the fill count alone decides a full list
      if (cmd.list_id >= NUM_LISTS || list_fill[cmd.list_id] >= LIST_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        list_mem[cmd.list_id][list_fill[cmd.list_id]] = cmd.value;
        list_fill[cmd.list_id]++;
        res.status = STAT_LOADED;
      end
    end else begin
      // scan the live heads; strict compare keeps ties on the lowest list
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (list_head[i] < list_fill[i]) begin
          if (!found || list_mem[i][list_head[i]] < list_mem[pick][list_head[pick]]) begin
            found = 1'b1;
            pick  = i;
          end
        end
      end
      if (found) begin
        res.out_value   = list_mem[pick][list_head[pick]];
        res.source_list = 4'(pick);
        res.status      = STAT_POPPED;
        list_head[pick]++;
      end else begin
        res.status = STAT_EMPTY;
      end
    end
    return res;
  endfunction

  // Track command beats and check each result beat against the oldest prediction
  always @(posedge clk) begin : watch
    out_item_t seen;
    out_item_t want;
    if (rst) begin
      foreach (list_fill[i]) begin
        list_fill[i] = 0;
        list_head[i] = 0;
      end
      results_due.delete();
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        results_due.push_back(apply_command(cmd_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        seen = res_ch.data;
        if (results_due.size() == 0) begin
          $error("result beat with nothing due: out_value %0d source_list %0d status %0d",
                 seen.out_value, seen.source_list, seen.status);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (seen.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, seen.out_value);
            errors++;
          end
          if (seen.source_list !== want.source_list) begin
            $error("source_list: expected %0d, got %0d", want.source_list, seen.source_list);
            errors++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            errors++;
          end
        end
      end
    end
    fail_count      <= errors;
    results_waiting <= results_due.size();
  end

endmodule

### bench/tb_top.sv
// Top of the k-way sorted merge bench: clock, reset, command stimulus, result-side
// stalls, watchdog and verdict. Depends on kwm_pkg, both channel interfaces,
// k_way_sorted_merge and kwm_merge_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam int NUM_LISTS    = 16;
  localparam int LIST_DEPTH   = 256;
  localparam int RANDOM_BEATS = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_START   = 1200;
  localparam int HOLD_LEN     = 500;
  localparam int DRAIN_CYCLES = 40;

  // unused command code; the block decodes it as clear
  localparam logic [1:0] MODE_SPARE = MODE_CLEAR | MODE_POP;

  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_e;

  logic clk;
  logic rst;
  int   fail_count;
  int   results_waiting;
  int   beats_sent = 0;
  int   burst_left = 0;

  kwm_in_if  cmd_ch ();
  kwm_out_if res_ch ();

  k_way_sorted_merge #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  kwm_merge_checker #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) merge_check (
    .clk             (clk),
    .rst             (rst),
    .cmd_ch          (cmd_ch),
    .res_ch          (res_ch),
    .fail_count      (fail_count),
    .results_waiting (results_waiting)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one command beat, opening a new burst after a random gap when due
  task automatic send_beat(input logic [1:0] mode, input logic [3:0] list,
                           input logic signed [31:0] value);
    in_item_t item;
    int       gap;
    item.mode    = mode;
    item.list_id = list;
    item.value   = value;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_ch.data  <= item;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    burst_left--;
    beats_sent++;
  endtask

  // Load a random set of ascending lists, then drain them with one pop too many
  task automatic merge_round();
    int     lens [NUM_LISTS];
    int     tails [NUM_LISTS];
    int     rounds;
    int     pops_left;
    bit     narrow;
    longint step;
    longint nxt;
    narrow    = ($urandom_range(0, 2) == 0);
    rounds    = 0;
    pops_left = 1;
    for (int i = 0; i < NUM_LISTS; i++) begin
      lens[i]  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      tails[i] = narrow ? int'($urandom_range(0, 3)) - 2 : int'($urandom);
      pops_left += lens[i];
      if (lens[i] > rounds)
        rounds = lens[i];
    end
    // interleave the lists, keeping each one ascending; slip in an early pop now and then
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (r < lens[i]) begin
          if (r > 0) begin
            case ($urandom_range(0, 3))
              0:       step = 0;
              1:       step = $urandom_range(0, 15);
              default: step = narrow ? $urandom_range(0, 2) : longint'($urandom);
            endcase
            nxt = longint'(tails[i]) + step;
            // hold the tail at its last value rather than wrap past the top of the range
            if (nxt <= 64'sd2147483647)
              tails[i] = int'(nxt);
          end
          send_beat(MODE_LOAD, 4'(i), tails[i]);
          if ($urandom_range(0, 5) == 0 && pops_left > 1) begin
            send_beat(MODE_POP, 4'($urandom), $urandom);
            pops_left--;
          end
        end
      end
    end
    while (pops_left > 0) begin
      send_beat(MODE_POP, 4'($urandom), $urandom);
      pops_left--;
    end
    // clear most of the time; otherwise let fill counts build up
    case ($urandom_range(0, 3))
      0:       send_beat(MODE_SPARE, 4'($urandom), $urandom);
      1, 2:    send_beat(MODE_CLEAR, 4'($urandom), $urandom);
      default: ;
    endcase
  endtask

  // Stimulus: reset, directed cases, one full list, then random rounds and noise
  initial begin : stimulus
    int target;
    int full_id;
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pop with every list empty, then extremes, ties and an unordered list
    send_beat(MODE_POP,   4'd0,  32'sd0);
    send_beat(MODE_LOAD,  4'd0,  32'sh8000_0000);
    send_beat(MODE_LOAD,  4'd15, 32'sh7FFF_FFFF);
    send_beat(MODE_LOAD,  4'd5,  32'sd0);
    send_beat(MODE_LOAD,  4'd5,  -32'sd1);
    send_beat(MODE_LOAD,  4'd3,  32'sd0);
    send_beat(MODE_LOAD,  4'd10, 32'shAAAA_AAAA);
    send_beat(MODE_LOAD,  4'd9,  32'sh5555_5555);
    send_beat(MODE_LOAD,  4'd15, 32'sh7FFF_FFFF);
    repeat (9) send_beat(MODE_POP, 4'hF, 32'shFFFF_FFFF);
    // spare code clears, as does a clear carrying stray fields
    send_beat(MODE_LOAD,  4'd7,  32'sd1);
    send_beat(MODE_SPARE, 4'hF,  32'shFFFF_FFFF);
    send_beat(MODE_POP,   4'd7,  32'sd0);
    send_beat(MODE_LOAD,  4'd2,  32'sd5);
    send_beat(MODE_CLEAR, 4'hA,  32'sh1234_5678);
    send_beat(MODE_POP,   4'd2,  32'sd0);

    // fill one list past its depth; pops must not make room again
    full_id = $urandom_range(0, NUM_LISTS - 1);
    for (int n = 0; n < LIST_DEPTH + 2; n++)
      send_beat(MODE_LOAD, 4'(full_id), $urandom);
    repeat (3) send_beat(MODE_POP, 4'($urandom), $urandom);
    send_beat(MODE_LOAD, 4'(full_id), $urandom);
    send_beat(MODE_LOAD, 4'(full_id + 1), $urandom);
    send_beat(MODE_POP, 4'($urandom), $urandom);
    send_beat(MODE_CLEAR, 4'($urandom), $urandom);

    // random part: mostly well-formed merge rounds, some raw noise
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      if ($urandom_range(0, 19) < 17) begin
        merge_round();
      end else begin
        repeat ($urandom_range(1, 10))
          send_beat(2'($urandom_range(0, 3)), 4'($urandom), $urandom);
      end
    end

    // drain and give the verdict, letting the checker count the last beat first
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_waiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall on a changing pattern, with one long hold-off to back up the input
  initial begin : receiver
    int unsigned cyc;
    rx_style_e   style;
    cyc   = 0;
    style = RX_OPEN;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (cyc % 100 == 0)
        style = rx_style_e'($urandom_range(0, 3));
      case (style)
        RX_OPEN:    res_ch.ready <= 1'b1;
        RX_COIN:    res_ch.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: res_ch.ready <= (cyc % 4 != 0);
        RX_SPARSE:  res_ch.ready <= ($urandom_range(0, 4) == 0);
        default:    res_ch.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
rtl/core/kwm_pkg.sv
rtl/core/kwm_in_if.sv
rtl/core/kwm_out_if.sv
rtl/core/k_way_sorted_merge.sv
bench/kwm_merge_checker.sv
bench/tb_top.sv
